// File: src/lslp_pkg.sv
// Shared types, widths and helpers of the least-squares line predictor.
package lslp_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int ID_W        = 10;
    localparam int COORD_W     = 16;
    localparam int PRED_W      = 18;

    localparam int ID_SUM_W = 16;
    localparam int ID_SQ_W  = 26;
    localparam int C_SUM_W  = 22;
    localparam int C_ID_W   = 32;

    // Solver widths.
    localparam int DEN_W  = COUNT_W + ID_SQ_W;           // n*Sii, den is never negative
    localparam int NA_W   = COUNT_W + C_ID_W;            // n*Sic
    localparam int SC_W   = ID_SUM_W + C_SUM_W;          // Si*Sc
    localparam int A_W    = NA_W + 1;                    // slope numerator, signed
    localparam int BP_W   = C_SUM_W + ID_SQ_W;           // Sc*Sii
    localparam int SIC_W  = ID_SUM_W + C_ID_W;           // Si*Sic
    localparam int B_W    = BP_W + 1;                    // intercept numerator, signed
    localparam int AQ_W   = A_W + ID_W + 1;              // slope numerator times q
    localparam int NUM_W  = AQ_W + 2;                    // full numerator, signed
    localparam int DVD_W  = NUM_W;                       // rounded magnitude, unsigned
    localparam int DCNT_W = $clog2(DVD_W + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_QUERY,
        KIND_CLEAR
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [ID_W-1:0]    id;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_DIFF,
        ST_SCALE,
        ST_SUM,
        ST_DIV_X,
        ST_DIV_Y,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               busy;
    } back_status_t;

    localparam logic [DVD_W-1:0] POS_LIMIT = DVD_W'(2 ** (PRED_W - 1) - 1);
    localparam logic [DVD_W-1:0] NEG_LIMIT = DVD_W'(2 ** (PRED_W - 1));

    // Apply the sign to a rounded magnitude and clamp to the signed result range.
    function automatic logic [PRED_W-1:0] sat_pred(input logic [DVD_W-1:0] mag,
                                                   input logic neg);
        logic [PRED_W-1:0] res;
        if (neg) begin
            if (mag > NEG_LIMIT) begin
                res = NEG_LIMIT[PRED_W-1:0];
            end
            else begin
                res = PRED_W'(~mag + 1'b1);
            end
        end
        else begin
            if (mag > POS_LIMIT) begin
                res = POS_LIMIT[PRED_W-1:0];
            end
            else begin
                res = mag[PRED_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

// File: src/least_squares_line_predictor_core.sv
// Top level of the two-channel least-squares line predictor.
//
// This block keeps running sums over accepted samples (id, x, y) and, on a
// query beat, returns the least-squares fit of x and y evaluated at the query
// id, rounded to nearest and saturated to signed Q17.0. Beats enter on the
// s_axis side; tuser carries the opcode (add sample, query, clear) and the
// sample-valid flag. A front decoder drops unused opcodes and invalid samples
// and places the rest in a four-entry queue. While idle, the back end takes
// one queued item per cycle, so samples and clears sustain one beat per cycle.
// A query occupies the back end after it leaves the queue: registered
// product, difference, scale and sum steps, then, if the fit is valid, the
// shared restoring divider forms the x and then the y quotient (53 quotient
// bits at one bit per cycle, then a completion flag), and then the result
// register is loaded, which waits if the previous result beat is not taken.
// While a query runs the queue keeps filling, and the input stalls once it is
// full. One result beat is produced per query on the m_axis side; its tuser
// bit is the pred_valid flag, which is low (with both predictions zero) when
// fewer than two samples are held or the id spread is zero. Samples beyond 64
// are dropped until a clear beat arrives.
module least_squares_line_predictor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sample_id[9:0], point_x[25:10], point_y[41:26], query_pos[51:42], zero pad
    input  logic [55:0] s_axis_tdata,
    // op[1:0], point_valid[2]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pred_x[17:0], pred_y[35:18], zero pad
    output logic [39:0] m_axis_tdata,
    // pred_valid[0]
    output logic [0:0]  m_axis_tuser
);
    import lslp_pkg::*;

    logic                 queue_full;
    logic                 queue_empty;
    logic                 push;
    logic                 pop;
    entry_t               push_entry;
    entry_t               head;
    logic [QLVL_W-1:0]    level;
    logic [PRED_W-1:0]    pred_x;
    logic [PRED_W-1:0]    pred_y;
    logic                 pred_valid;
    back_status_t         status;

    lslp_front u_front (
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_user    (s_axis_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    lslp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .empty      (queue_empty),
        .level      (level)
    );

    lslp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .pred_x      (pred_x),
        .pred_y      (pred_y),
        .pred_valid  (pred_valid),
        .status      (status)
    );

    assign m_axis_tdata = {4'b0, pred_y, pred_x};
    assign m_axis_tuser = pred_valid;

    // The sample count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.count <= COUNT_W'(MAX_SAMPLES))
        else $error("sample count above capacity");

    // The queue level stays within its depth.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= QLVL_W'(QUEUE_DEPTH))
        else $error("queue level above depth");

    // A result flagged invalid carries zero predictions.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("invalid result with nonzero data");

    // The back end only takes queue items when it is idle.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.busy)
        else $error("queue popped while solver busy");

endmodule

// File: src/lslp_front.sv
// Front end: decodes incoming beats and forwards the useful ones to the queue.
module lslp_front (
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [55:0]             in_data,
    input  logic [2:0]              in_user,
    input  logic                    queue_full,
    output logic                    push,
    output lslp_pkg::entry_t        push_entry
);
    import lslp_pkg::*;

    logic [1:0] op;
    logic       point_valid;
    logic       keep;

    assign op          = in_user[1:0];
    assign point_valid = in_user[2];
    assign in_ready    = !queue_full;

    // Invalid samples and the unused opcode never reach the back end.
    always_comb
    begin
        keep            = 1'b0;
        push_entry.kind = KIND_ADD;
        push_entry.id   = in_data[9:0];
        push_entry.x    = in_data[25:10];
        push_entry.y    = in_data[41:26];
        case (op)
            OP_ADD:
            begin
                keep = point_valid;
            end
            OP_QUERY:
            begin
                keep            = 1'b1;
                push_entry.kind = KIND_QUERY;
                push_entry.id   = in_data[51:42];
            end
            OP_CLEAR:
            begin
                keep            = 1'b1;
                push_entry.kind = KIND_CLEAR;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = in_valid && !queue_full && keep;

endmodule

// File: src/lslp_queue.sv
// Short queue of decoded items between the front end and the back end.
module lslp_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  lslp_pkg::entry_t             push_entry,
    output logic                         full,
    input  logic                         pop,
    output lslp_pkg::entry_t             head,
    output logic                         empty,
    output logic [lslp_pkg::QLVL_W-1:0]  level
);
    import lslp_pkg::*;

    entry_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QLVL_W-1:0]   level_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (level_reg == QLVL_W'(QUEUE_DEPTH));
    assign empty   = (level_reg == '0);
    assign level   = level_reg;
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/lslp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lslp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lslp_pkg::DVD_W-1:0]  dividend,
    input  logic [lslp_pkg::DEN_W-1:0]  divisor,
    output logic                        done,
    output logic [lslp_pkg::DVD_W-1:0]  quotient
);
    import lslp_pkg::*;

    logic [DEN_W:0]    rem_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  div_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              done_reg;
    logic [DEN_W:0]    trial;
    logic              fits;

    assign trial    = {rem_reg[DEN_W-1:0], quo_reg[DVD_W-1]};
    assign fits     = (trial >= {1'b0, div_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? (trial - {1'b0, div_reg}) : trial;
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= DCNT_W'(DVD_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: src/lslp_back.sv
// Back end: running sums, the line solver sequencer and the result register.
module lslp_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         queue_empty,
    input  lslp_pkg::entry_t             head,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lslp_pkg::PRED_W-1:0]  pred_x,
    output logic [lslp_pkg::PRED_W-1:0]  pred_y,
    output logic                         pred_valid,
    output lslp_pkg::back_status_t       status
);
    import lslp_pkg::*;

    back_state_t state_reg, state_next;

    logic [COUNT_W-1:0]  n_reg;
    logic [ID_SUM_W-1:0] si_reg;
    logic [ID_SQ_W-1:0]  sii_reg;
    logic [C_SUM_W-1:0]  sx_reg, sy_reg;
    logic [C_ID_W-1:0]   sxi_reg, syi_reg;
    logic [ID_W-1:0]     q_reg;

    logic [DEN_W-1:0]    den_a_reg;
    logic [2*ID_SUM_W-1:0] den_b_reg;
    logic [NA_W-1:0]     p1x_reg, p1y_reg;
    logic [SC_W-1:0]     p2x_reg, p2y_reg;
    logic [BP_W-1:0]     p3x_reg, p3y_reg;
    logic [SIC_W-1:0]    p4x_reg, p4y_reg;
    logic [DEN_W-1:0]    den_reg;
    logic signed [A_W-1:0]  ax_reg, ay_reg;
    logic signed [B_W-1:0]  bx_reg, by_reg;
    logic signed [AQ_W-1:0] aqx_reg, aqy_reg;
    logic signed [NUM_W-1:0] numx_reg, numy_reg;
    logic [PRED_W-1:0]   resx_reg;

    logic                out_valid_reg;
    logic [PRED_W-1:0]   out_x_reg, out_y_reg;
    logic                out_pv_reg;

    // Sequencer controls.
    logic pop_c, acc_en, clr_en, start_x, start_y, load_x, out_load, fit_bad;

    logic                div_start;
    logic [DVD_W-1:0]    div_dividend;
    logic                div_done;
    logic [DVD_W-1:0]    div_quot;
    logic [DVD_W-1:0]    magx, magy;
    logic [2*ID_W-1:0]   id_sq;
    logic                room;
    logic                out_free;

    assign room     = (n_reg < COUNT_W'(MAX_SAMPLES));
    assign out_free = !out_valid_reg || out_ready;
    assign fit_bad  = (n_reg < COUNT_W'(2)) || (den_reg == '0);
    assign id_sq    = head.id * head.id;

    assign magx = numx_reg[NUM_W-1] ? DVD_W'(-numx_reg) : DVD_W'(numx_reg);
    assign magy = numy_reg[NUM_W-1] ? DVD_W'(-numy_reg) : DVD_W'(numy_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty && head.kind == KIND_QUERY)
                begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD:  state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_SUM;
            ST_SUM:   state_next = fit_bad ? ST_OUT : ST_DIV_X;
            ST_DIV_X:
            begin
                if (div_done)
                begin
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Controls.
    always_comb
    begin
        pop_c    = 1'b0;
        acc_en   = 1'b0;
        clr_en   = 1'b0;
        start_x  = 1'b0;
        start_y  = 1'b0;
        load_x   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop_c  = 1'b1;
                    acc_en = (head.kind == KIND_ADD) && room;
                    clr_en = (head.kind == KIND_CLEAR);
                end
            end
            ST_SUM:
            begin
                start_x = !fit_bad;
            end
            ST_DIV_X:
            begin
                load_x  = div_done;
                start_y = div_done;
            end
            ST_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
                pop_c = 1'b0;
            end
        endcase
    end

    assign pop          = pop_c;
    assign div_start    = start_x || start_y;
    assign div_dividend = (start_y ? magy : magx) + DVD_W'(den_reg >> 1);

    lslp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Solver datapath.
    always_ff @(posedge clk)
    begin
        if (pop_c)
        begin
            q_reg <= head.id;
        end
        den_a_reg <= DEN_W'(n_reg) * DEN_W'(sii_reg);
        den_b_reg <= si_reg * si_reg;
        p1x_reg   <= NA_W'(n_reg) * NA_W'(sxi_reg);
        p1y_reg   <= NA_W'(n_reg) * NA_W'(syi_reg);
        p2x_reg   <= SC_W'(si_reg) * SC_W'(sx_reg);
        p2y_reg   <= SC_W'(si_reg) * SC_W'(sy_reg);
        p3x_reg   <= BP_W'(sx_reg) * BP_W'(sii_reg);
        p3y_reg   <= BP_W'(sy_reg) * BP_W'(sii_reg);
        p4x_reg   <= SIC_W'(si_reg) * SIC_W'(sxi_reg);
        p4y_reg   <= SIC_W'(si_reg) * SIC_W'(syi_reg);
        den_reg   <= den_a_reg - DEN_W'(den_b_reg);
        ax_reg    <= $signed({1'b0, p1x_reg}) - $signed(A_W'(p2x_reg));
        ay_reg    <= $signed({1'b0, p1y_reg}) - $signed(A_W'(p2y_reg));
        bx_reg    <= $signed({1'b0, p3x_reg}) - $signed(B_W'(p4x_reg));
        by_reg    <= $signed({1'b0, p3y_reg}) - $signed(B_W'(p4y_reg));
        aqx_reg   <= AQ_W'(ax_reg) * AQ_W'($signed({1'b0, q_reg}));
        aqy_reg   <= AQ_W'(ay_reg) * AQ_W'($signed({1'b0, q_reg}));
        numx_reg  <= NUM_W'(aqx_reg) + NUM_W'(bx_reg);
        numy_reg  <= NUM_W'(aqy_reg) + NUM_W'(by_reg);
        if (load_x)
        begin
            resx_reg <= sat_pred(div_quot, numx_reg[NUM_W-1]);
        end
        if (out_load)
        begin
            if (fit_bad)
            begin
                out_x_reg  <= '0;
                out_y_reg  <= '0;
                out_pv_reg <= 1'b0;
            end
            else
            begin
                out_x_reg  <= resx_reg;
                out_y_reg  <= sat_pred(div_quot, numy_reg[NUM_W-1]);
                out_pv_reg <= 1'b1;
            end
        end
    end

    // Running sums and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            si_reg        <= '0;
            sii_reg       <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            sxi_reg       <= '0;
            syi_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (clr_en)
            begin
                n_reg   <= '0;
                si_reg  <= '0;
                sii_reg <= '0;
                sx_reg  <= '0;
                sy_reg  <= '0;
                sxi_reg <= '0;
                syi_reg <= '0;
            end
            else if (acc_en)
            begin
                n_reg   <= n_reg + 1'b1;
                si_reg  <= si_reg + ID_SUM_W'(head.id);
                sii_reg <= sii_reg + ID_SQ_W'(id_sq);
                sx_reg  <= sx_reg + C_SUM_W'(head.x);
                sy_reg  <= sy_reg + C_SUM_W'(head.y);
                sxi_reg <= sxi_reg + C_ID_W'(head.x) * C_ID_W'(head.id);
                syi_reg <= syi_reg + C_ID_W'(head.y) * C_ID_W'(head.id);
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign pred_x       = out_x_reg;
    assign pred_y       = out_y_reg;
    assign pred_valid   = out_pv_reg;
    assign status.count = n_reg;
    assign status.busy  = (state_reg != ST_IDLE);

endmodule

// File: test/tb_least_squares_line_predictor_core.sv
// Testbench of the least-squares line predictor: random and directed beats against a local fit.
`timescale 1ns / 100ps

module tb_least_squares_line_predictor_core;
    import lslp_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    typedef struct packed {
        logic [17:0] px;
        logic [17:0] py;
        logic        ok;
    } fit_t;

    // Running sums held exactly, mirrored from the accumulators of the block.
    longint held_n, held_si, held_sii, held_sx, held_sxi, held_sy, held_syi;
    fit_t   fits_pending[$];
    int     errors = 0;
    bit     sink_stalls = 1'b1;

    always #2 clk = ~clk;

    least_squares_line_predictor_core dut (.*);

    // One channel of the fit: exact numerator, round half away from zero, clamp.
    function automatic logic [17:0] fit_coord(longint sc, longint sic, longint den, longint q);
        longint num, mag, r, v;
        num = (held_n * sic - held_si * sc) * q + sc * held_sii - held_si * sic;
        mag = (num < 0) ? -num : num;
        r   = (mag + den / 2) / den;
        if (num < 0)
            v = (r > 131072) ? -131072 : -r;
        else
            v = (r > 131071) ? 131071 : r;
        return v[17:0];
    endfunction

    function automatic void predict_beat(logic [1:0] op, logic [9:0] id, logic [15:0] x,
                                         logic [15:0] y, logic pv, logic [9:0] q);
        longint den;
        fit_t   f;
        if (op == OP_ADD) begin
            if (pv && held_n < MAX_SAMPLES) begin
                held_n++;
                held_si  += id;
                held_sii += longint'(id) * id;
                held_sx  += x;
                held_sxi += longint'(x) * id;
                held_sy  += y;
                held_syi += longint'(y) * id;
            end
        end
        else if (op == OP_CLEAR) begin
            {held_n, held_si, held_sii, held_sx, held_sxi, held_sy, held_syi} = '0;
        end
        else if (op == OP_QUERY) begin
            den = held_n * held_sii - held_si * held_si;
            f = '0;
            if (held_n >= 2 && den > 0) begin
                f.px = fit_coord(held_sx, held_sxi, den, q);
                f.py = fit_coord(held_sy, held_syi, den, q);
                f.ok = 1'b1;
            end
            fits_pending.insert(fits_pending.size(), f);
        end
    endfunction

    // The valid line stays high after a beat; it drops only before an idle gap.
    task automatic send_beat(logic [1:0] op, logic [9:0] id, logic [15:0] x,
                             logic [15:0] y, logic pv, logic [9:0] q);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, q, y, x, id};
        s_axis_tuser  <= {pv, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_beat(op, id, x, y, pv, q);
    endtask

    task automatic hold_input();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic random_sample(logic [9:0] base);
        send_beat(OP_ADD, base + 10'($urandom_range(0, 40)), 16'($urandom),
                  16'($urandom), 1'b1, 10'($urandom));
    endtask

    // Field extremes, each opcode and every special case in a short run.
    task automatic test_directed();
        send_beat(OP_QUERY, 0, 0, 0, 1, 10'd5);          // empty: not valid
        send_beat(OP_ADD, 10'd3, 16'hFFFF, 16'h0000, 1, 0);
        send_beat(OP_QUERY, 0, 0, 0, 0, 10'd3);          // one sample only
        send_beat(OP_ADD, 10'd3, 16'h1234, 16'hFFFF, 1, 0);
        send_beat(OP_QUERY, 0, 0, 0, 0, 10'd3);          // same id twice: zero spread
        send_beat(OP_ADD, 10'd1023, 16'h0000, 16'hFFFF, 1, 10'h3FF);
        send_beat(OP_ADD, 10'd500, 16'hFFFF, 16'hFFFF, 0, 0); // skipped sample
        send_beat(OP_QUERY, 10'h3FF, 16'hFFFF, 16'hFFFF, 1, 10'd0);
        send_beat(OP_QUERY, 0, 0, 0, 0, 10'h3FF);
        send_beat(OP_SPARE, 10'h3FF, 16'hFFFF, 16'hFFFF, 1, 10'h3FF); // unused opcode
        send_beat(OP_CLEAR, 10'h3FF, 16'hFFFF, 16'hFFFF, 1, 10'h3FF);
        send_beat(OP_QUERY, 0, 0, 0, 0, 10'd7);
        // Steep lines to drive both ends of the saturation.
        send_beat(OP_ADD, 10'd0, 16'h0000, 16'hFFFF, 1, 0);
        send_beat(OP_ADD, 10'd1, 16'hFFFF, 16'h0000, 1, 0);
        send_beat(OP_QUERY, 0, 0, 0, 0, 10'h3FF);
        send_beat(OP_QUERY, 0, 0, 0, 0, 10'd0);
        send_beat(OP_CLEAR, 0, 0, 0, 0, 0);
    endtask

    // Fill past capacity so that extra samples are dropped, then query.
    task automatic test_full();
        repeat (70)
            random_sample(10'd100);
        send_beat(OP_QUERY, 0, 0, 0, 0, 10'($urandom));
        send_beat(OP_CLEAR, 0, 0, 0, 0, 0);
    endtask

    // Hold back until the block has drained every pending fit.
    task automatic test_drain();
        send_beat(OP_ADD, 10'd2, 16'd50, 16'd60, 1, 0);
        send_beat(OP_ADD, 10'd9, 16'd90, 16'd20, 1, 0);
        send_beat(OP_QUERY, 0, 0, 0, 0, 10'd4);
        send_beat(OP_QUERY, 0, 0, 0, 0, 10'd1000);
        hold_input();
        @(posedge clk);
        while (fits_pending.size() != 0)
            @(posedge clk);
        send_beat(OP_QUERY, 0, 0, 0, 0, 10'd600);
        send_beat(OP_CLEAR, 0, 0, 0, 0, 0);
    endtask

    // Mostly runs of samples followed by queries, with noise mixed in.
    task automatic test_random(int beats);
        int k, run;
        logic [9:0] base;
        k = 0;
        while (k < beats) begin
            base = 10'($urandom_range(0, 980));
            run  = $urandom_range(0, 12);
            if ($urandom_range(0, 9) == 0)
                run = $urandom_range(60, 70);
            sink_stalls = ($urandom_range(0, 3) != 0);
            repeat (run) begin
                if ($urandom_range(0, 9) == 0)
                    send_beat(OP_ADD, 10'($urandom), 16'($urandom), 16'($urandom),
                              1'b0, 10'($urandom));
                else
                    random_sample(base);
                k++;
            end
            repeat ($urandom_range(1, 3)) begin
                send_beat(($urandom_range(0, 7) == 0) ? OP_SPARE : OP_QUERY,
                          10'($urandom), 16'($urandom), 16'($urandom),
                          1'($urandom), 10'($urandom));
                k++;
            end
            if ($urandom_range(0, 2) == 0) begin
                send_beat(OP_CLEAR, 10'($urandom), 16'($urandom), 16'($urandom),
                          1'($urandom), 10'($urandom));
                k++;
            end
        end
        sink_stalls = 1'b1;
    endtask

    // Result side: random ready gaps, compare each beat with the oldest fit.
    initial begin
        int stall;
        fit_t f;
        forever begin
            stall = sink_stalls ? $urandom_range(0, 7) : 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            if (fits_pending.size() == 0) begin
                $display("%0t: unexpected result beat %h/%b", $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else begin
                f = fits_pending.pop_front();
                if (m_axis_tdata[17:0] !== f.px) begin
                    $display("%0t: pred_x exp %h act %h", $time, f.px, m_axis_tdata[17:0]);
                    errors++;
                end
                if (m_axis_tdata[35:18] !== f.py) begin
                    $display("%0t: pred_y exp %h act %h", $time, f.py, m_axis_tdata[35:18]);
                    errors++;
                end
                if (m_axis_tuser[0] !== f.ok) begin
                    $display("%0t: pred_valid exp %b act %b", $time, f.ok, m_axis_tuser[0]);
                    errors++;
                end
            end
        end
    end

    initial begin
        int guard;
        {held_n, held_si, held_sii, held_sx, held_sxi, held_sy, held_syi} = '0;
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full();
        test_drain();
        test_random(955);
        hold_input();
        guard = 0;
        while (fits_pending.size() != 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        if (errors == 0 && fits_pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
